### rtl/bsfr_pkg.sv
// Shared types and constants for the byte-stuffed frame receiver.
`default_nettype none
package bsfr_pkg;

   localparam logic [7:0] FLAG_BYTE   = 8'h7e;
   localparam logic [7:0] CTRL_INFO   = 8'h03;
   localparam logic [7:0] CTRL_DISC   = 8'h77;
   localparam logic [7:0] ESC_BYTE    = 8'h7d;
   localparam logic [7:0] ESC_OF_ESC  = 8'h5d;
   localparam logic [7:0] ESC_OF_FLAG = 8'h5e;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_PAYLOAD   = 1'd1;

   // Result event codes
   localparam logic [1:0] EV_PAYLOAD = 2'd0;
   localparam logic [1:0] EV_GOOD    = 2'd1;
   localparam logic [1:0] EV_BAD     = 2'd2;
   localparam logic [1:0] EV_DISC    = 2'd3;

   // Operation codes passed from front to back
   localparam logic [1:0] OP_DATA  = 2'd0;
   localparam logic [1:0] OP_CLOSE = 2'd1;
   localparam logic [1:0] OP_DISC  = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
   } op_entry_type;

endpackage
`default_nettype wire

### rtl/bsfr_front.sv
// Header tracker: follows flag, address, control and header check, and queues data-field and disconnect work.
`default_nettype none
module bsfr_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic               queue_full,
   input  wire logic [7:0]         frame_address,
   output logic                    req_stall,
   output logic                    push,
   output bsfr_pkg::op_entry_type  push_entry
);
   import bsfr_pkg::*;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_FLAG      = 3'd1;
   localparam logic [2:0] PH_ADDR      = 3'd2;
   localparam logic [2:0] PH_INFO_CTRL = 3'd3;
   localparam logic [2:0] PH_DATA      = 3'd4;
   localparam logic [2:0] PH_DISC_CTRL = 3'd5;
   localparam logic [2:0] PH_DISC_DONE = 3'd6;

   logic [2:0] phase_ff;
   logic [2:0] phase_in;
   logic       accept;
   logic       is_flag;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_flag   = (req_rx_byte == FLAG_BYTE);

   always_comb begin
      phase_in        = phase_ff;
      push            = 1'b0;
      push_entry.op   = OP_DATA;
      push_entry.data = req_rx_byte;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (is_flag) phase_in = PH_FLAG;
            end
            PH_FLAG: begin
               if (is_flag) phase_in = PH_FLAG;
               else if (req_rx_byte == frame_address) phase_in = PH_ADDR;
               else phase_in = PH_IDLE;
            end
            PH_ADDR: begin
               if (is_flag) phase_in = PH_FLAG;
               else if (req_rx_byte == CTRL_INFO) phase_in = PH_INFO_CTRL;
               else if (req_rx_byte == CTRL_DISC) phase_in = PH_DISC_CTRL;
               else phase_in = PH_IDLE;
            end
            PH_INFO_CTRL: begin
               if (is_flag) phase_in = PH_FLAG;
               else if (req_rx_byte == (frame_address ^ CTRL_INFO)) phase_in = PH_DATA;
               else phase_in = PH_IDLE;
            end
            PH_DATA: begin
               push = 1'b1;
               if (is_flag) begin
                  push_entry.op = OP_CLOSE;
                  phase_in      = PH_FLAG;
               end
            end
            PH_DISC_CTRL: begin
               if (is_flag) phase_in = PH_FLAG;
               else if (req_rx_byte == (frame_address ^ CTRL_DISC)) phase_in = PH_DISC_DONE;
               else phase_in = PH_IDLE;
            end
            PH_DISC_DONE: begin
               // ignore trailer bytes until the flag
               if (is_flag) begin
                  push          = 1'b1;
                  push_entry.op = OP_DISC;
                  phase_in      = PH_FLAG;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

### rtl/bsfr_queue.sv
// Short queue of data-field and disconnect operations between header tracker and destuffer.
`default_nettype none
module bsfr_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire bsfr_pkg::op_entry_type  push_entry,
   input  wire logic                    pop,
   output logic                         full,
   output logic                         not_empty,
   output bsfr_pkg::op_entry_type       head
);
   import bsfr_pkg::*;

   op_entry_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]  wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0]  wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]  rd_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0]  rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]  count_ff;
   logic [QUEUE_CNT_WIDTH-1:0]  count_in;
   logic                        do_pop;

   assign full      = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) count_in = count_ff + 1'b1;
      else if (!push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_entry;
   end

endmodule
`default_nettype wire

### rtl/bsfr_back.sv
// Destuffer: undoes escapes, delays payload by one byte, keeps XOR check and count, gives verdicts.
`default_nettype none
module bsfr_back #(
   parameter int COUNT_WIDTH = 13
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    op_valid,
   input  wire bsfr_pkg::op_entry_type  op_entry,
   input  wire logic [COUNT_WIDTH-1:0]  max_payload,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [1:0]                   rsp_event_kind,
   output logic [7:0]                   rsp_out_byte,
   output logic [COUNT_WIDTH-1:0]       rsp_payload_count
);
   import bsfr_pkg::*;

   logic                   escape_ff,   escape_in;
   logic [7:0]             xor_ff,      xor_in;
   logic [7:0]             held_ff,     held_in;
   logic                   held_vld_ff, held_vld_in;
   logic [COUNT_WIDTH-1:0] count_ff,    count_in;
   logic                   error_ff,    error_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             kind_ff,      kind_in;
   logic [7:0]             obyte_ff,     obyte_in;
   logic [COUNT_WIDTH-1:0] ocount_ff,    ocount_in;

   logic                   take;
   logic [7:0]             take_byte;
   logic                   emit;

   assign pop = op_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      escape_in   = escape_ff;
      xor_in      = xor_ff;
      held_in     = held_ff;
      held_vld_in = held_vld_ff;
      count_in    = count_ff;
      error_in    = error_ff;
      take        = 1'b0;
      take_byte   = op_entry.data;
      emit        = 1'b0;
      kind_in     = EV_PAYLOAD;
      obyte_in    = '0;
      ocount_in   = '0;

      if (pop) begin
         unique case (op_entry.op)
            OP_DATA: begin
               if (escape_ff) begin
                  escape_in = 1'b0;
                  if (op_entry.data == ESC_OF_FLAG) begin
                     take      = 1'b1;
                     take_byte = FLAG_BYTE;
                  end else if (op_entry.data == ESC_OF_ESC) begin
                     take      = 1'b1;
                     take_byte = ESC_BYTE;
                  end else begin
                     error_in = 1'b1;
                  end
               end else if (op_entry.data == ESC_BYTE) begin
                  escape_in = 1'b1;
               end else begin
                  take = 1'b1;
               end
            end
            OP_CLOSE: begin
               emit      = 1'b1;
               kind_in   = (held_vld_ff && !escape_ff && !error_ff && held_ff == xor_ff)
                           ? EV_GOOD : EV_BAD;
               ocount_in = count_ff;
               escape_in   = 1'b0;
               xor_in      = '0;
               held_in     = '0;
               held_vld_in = 1'b0;
               count_in    = '0;
               error_in    = 1'b0;
            end
            OP_DISC: begin
               emit    = 1'b1;
               kind_in = EV_DISC;
            end
            default: begin
            end
         endcase

         // release the held byte, hold the new one
         if (take) begin
            if (held_vld_ff) begin
               if (count_ff >= max_payload) begin
                  error_in = 1'b1;
               end else begin
                  xor_in   = xor_ff ^ held_ff;
                  count_in = count_ff + 1'b1;
                  emit     = 1'b1;
                  kind_in  = EV_PAYLOAD;
                  obyte_in = held_ff;
               end
            end
            held_in     = take_byte;
            held_vld_in = 1'b1;
         end
      end

      if (pop) rsp_valid_in = emit;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff    <= 1'b0;
         xor_ff       <= '0;
         held_ff      <= '0;
         held_vld_ff  <= 1'b0;
         count_ff     <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         escape_ff    <= escape_in;
         xor_ff       <= xor_in;
         held_ff      <= held_in;
         held_vld_ff  <= held_vld_in;
         count_ff     <= count_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result while stalled
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         kind_ff   <= kind_in;
         obyte_ff  <= obyte_in;
         ocount_ff <= ocount_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_out_byte      = obyte_ff;
   assign rsp_payload_count = ocount_ff;

endmodule
`default_nettype wire

### rtl/byte_stuffed_frame_receiver.sv
// Top level of the byte-stuffed frame receiver: config registers, front, queue and back.
// Takes one received byte per cycle while req_stall is low. A header tracker checks flag,
// address, control and header check and forwards data-field bytes and closing flags through
// a two-entry queue to a destuffer, which undoes escapes, releases each payload byte one byte
// late (the last byte before the closing flag is the XOR check), counts up to max_payload
// and gives a good/bad verdict with the count, or reports a disconnect frame. Sustained rate
// is one byte per cycle while rsp_stall is low; a result passes through the queue entry and
// then the output register. rsp_stall backs up into the queue and then req_stall.
`default_nettype none
module byte_stuffed_frame_receiver #(
   parameter int COUNT_WIDTH = 13
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [7:0]                              req_rx_byte,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic [1:0]                                   rsp_event_kind,
   output logic [7:0]                                   rsp_out_byte,
   output logic [COUNT_WIDTH-1:0]                       rsp_payload_count,
   input  wire logic                                    csr_write_enable,
   input  wire logic [bsfr_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [COUNT_WIDTH-1:0]                  csr_write_data
);
   import bsfr_pkg::*;

   logic [7:0]             frame_address_ff;
   logic [COUNT_WIDTH-1:0] max_payload_ff;

   logic         q_push;
   op_entry_type q_push_entry;
   logic         q_full;
   logic         q_not_empty;
   op_entry_type q_head;
   logic         q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_address_ff <= 8'd3;
         max_payload_ff   <= COUNT_WIDTH'(250);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_ADDRESS: frame_address_ff <= csr_write_data[7:0];
            CSR_MAX_PAYLOAD:   max_payload_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   bsfr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_rx_byte   (req_rx_byte),
      .queue_full    (q_full),
      .frame_address (frame_address_ff),
      .req_stall     (req_stall),
      .push          (q_push),
      .push_entry    (q_push_entry)
   );

   bsfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   bsfr_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .op_valid          (q_not_empty),
      .op_entry          (q_head),
      .max_payload       (max_payload_ff),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_payload_count (rsp_payload_count)
   );

   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("queue written while full");

   a_verdict_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind != EV_PAYLOAD) |-> (rsp_out_byte == 8'd0))
      else $error("non-payload transaction carries a byte");

   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == EV_PAYLOAD || rsp_event_kind == EV_DISC))
         |-> (rsp_payload_count == '0))
      else $error("count set on payload or disconnect transaction");

endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the byte-stuffed frame receiver.
module tb;
   import bsfr_pkg::*;

   localparam int COUNT_WIDTH = 13;
   localparam int COUNT_TOP = (1 << COUNT_WIDTH) - 1;

   typedef enum logic [2:0] {
      HUNT, GOT_FLAG, GOT_ADDR, GOT_INFO, IN_DATA, GOT_DISC, DISC_TRAILER
   } rx_phase_type;

   typedef struct {
      logic [1:0]             kind;
      logic [7:0]             data;
      logic [COUNT_WIDTH-1:0] count;
   } rx_event_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [7:0]                   req_rx_byte;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [1:0]                   rsp_event_kind;
   logic [7:0]                   rsp_out_byte;
   logic [COUNT_WIDTH-1:0]       rsp_payload_count;
   logic                         csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index;
   logic [COUNT_WIDTH-1:0]       csr_write_data;

   byte_stuffed_frame_receiver #(.COUNT_WIDTH(COUNT_WIDTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_payload_count (rsp_payload_count),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // Predictor copy of the registers and the deframer state
   logic [7:0]             cfg_address;
   logic [COUNT_WIDTH-1:0] cfg_max_payload;
   rx_phase_type           rx_phase;
   bit                     esc_pending;
   logic [7:0]             check_acc;
   logic [7:0]             held_data;
   bit                     held_ok;
   logic [COUNT_WIDTH-1:0] delivered;
   bit                     frame_bad;

   rx_event_type pending_events[$];

   int send_idle_pct;
   int recv_stall_pct;
   int bytes_sent;
   int mismatches;
   int seen_payload, seen_good, seen_bad, seen_disc;
   logic [7:0] last_sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("byte_stuffed_frame_receiver test failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Compare each delivered transaction against the oldest prediction
   always @(posedge clock) begin
      rx_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            $error("unexpected result: event_kind %0d out_byte %0h payload_count %0d",
                   rsp_event_kind, rsp_out_byte, rsp_payload_count);
            mismatches++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_kind !== want.kind) begin
               $error("event_kind: expected %0d, got %0d", want.kind, rsp_event_kind);
               mismatches++;
            end
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %0h, got %0h", want.data, rsp_out_byte);
               mismatches++;
            end
            if (rsp_payload_count !== want.count) begin
               $error("payload_count: expected %0d, got %0d", want.count,
                      rsp_payload_count);
               mismatches++;
            end
            case (want.kind)
               EV_PAYLOAD: seen_payload++;
               EV_GOOD:    seen_good++;
               EV_BAD:     seen_bad++;
               default:    seen_disc++;
            endcase
         end
      end
   end

   task automatic push_event(input logic [1:0] kind, input logic [7:0] data,
                             input logic [COUNT_WIDTH-1:0] count);
      rx_event_type ev;
      ev.kind = kind;
      ev.data = data;
      ev.count = count;
      pending_events.push_back(ev);
   endtask

   task automatic clear_frame_state();
      esc_pending = 1'b0;
      check_acc = '0;
      held_data = '0;
      held_ok = 1'b0;
      delivered = '0;
      frame_bad = 1'b0;
   endtask

   // Release the held byte if the limit allows, then hold the new one
   task automatic take_payload(input logic [7:0] d);
      logic [COUNT_WIDTH-1:0] lim;
      lim = (cfg_max_payload < COUNT_TOP) ? cfg_max_payload : COUNT_WIDTH'(COUNT_TOP);
      if (held_ok) begin
         if (delivered >= lim) begin
            frame_bad = 1'b1;
         end else begin
            check_acc ^= held_data;
            delivered++;
            push_event(EV_PAYLOAD, held_data, '0);
         end
      end
      held_data = d;
      held_ok = 1'b1;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      bit good;
      logic [COUNT_WIDTH-1:0] cnt;
      case (rx_phase)
         HUNT: begin
            if (b == FLAG_BYTE) rx_phase = GOT_FLAG;
         end
         GOT_FLAG: begin
            if (b == FLAG_BYTE) rx_phase = GOT_FLAG;
            else if (b == cfg_address) rx_phase = GOT_ADDR;
            else rx_phase = HUNT;
         end
         GOT_ADDR: begin
            if (b == FLAG_BYTE) rx_phase = GOT_FLAG;
            else if (b == CTRL_INFO) rx_phase = GOT_INFO;
            else if (b == CTRL_DISC) rx_phase = GOT_DISC;
            else rx_phase = HUNT;
         end
         GOT_INFO: begin
            if (b == FLAG_BYTE) begin
               rx_phase = GOT_FLAG;
            end else if (b == (cfg_address ^ CTRL_INFO)) begin
               clear_frame_state();
               rx_phase = IN_DATA;
            end else begin
               rx_phase = HUNT;
            end
         end
         IN_DATA: begin
            if (b == FLAG_BYTE) begin
               good = held_ok && !esc_pending && !frame_bad && held_data == check_acc;
               cnt = delivered;
               clear_frame_state();
               rx_phase = GOT_FLAG;
               push_event(good ? EV_GOOD : EV_BAD, '0, cnt);
            end else if (esc_pending) begin
               esc_pending = 1'b0;
               if (b == ESC_OF_FLAG) take_payload(FLAG_BYTE);
               else if (b == ESC_OF_ESC) take_payload(ESC_BYTE);
               else frame_bad = 1'b1;
            end else if (b == ESC_BYTE) begin
               esc_pending = 1'b1;
            end else begin
               take_payload(b);
            end
         end
         GOT_DISC: begin
            if (b == FLAG_BYTE) rx_phase = GOT_FLAG;
            else if (b == (cfg_address ^ CTRL_DISC)) rx_phase = DISC_TRAILER;
            else rx_phase = HUNT;
         end
         DISC_TRAILER: begin
            if (b == FLAG_BYTE) begin
               rx_phase = GOT_FLAG;
               push_event(EV_DISC, '0, '0);
            end
         end
         default: rx_phase = HUNT;
      endcase
   endtask

   // Runs from a falling edge and returns on the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      predict_byte(b);
      bytes_sent++;
      last_sent = b;
      @(negedge clock);
   endtask

   task automatic send_stuffed(input logic [7:0] d);
      if (d == FLAG_BYTE) begin
         send_byte(ESC_BYTE);
         send_byte(ESC_OF_FLAG);
      end else if (d == ESC_BYTE) begin
         send_byte(ESC_BYTE);
         send_byte(ESC_OF_ESC);
      end else begin
         send_byte(d);
      end
   endtask

   task automatic send_header(input logic [7:0] ctrl);
      send_byte(cfg_address);
      send_byte(ctrl);
      send_byte(cfg_address ^ ctrl);
   endtask

   function automatic logic [7:0] pick_payload();
      case ($urandom_range(7))
         0: return FLAG_BYTE;
         1: return ESC_BYTE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_info_frame(input int len, input bit corrupt, input bit open_flag);
      logic [7:0] chk;
      logic [7:0] d;
      chk = '0;
      if (open_flag) send_byte(FLAG_BYTE);
      send_header(CTRL_INFO);
      for (int i = 0; i < len; i++) begin
         d = pick_payload();
         chk ^= d;
         send_stuffed(d);
      end
      if (corrupt) chk ^= 8'(1 << $urandom_range(7));
      send_stuffed(chk);
      send_byte(FLAG_BYTE);
   endtask

   // Hold the sender until every prediction is met, then let the pipe drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [COUNT_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      if (idx == CSR_FRAME_ADDRESS) cfg_address = value[7:0];
      else cfg_max_payload = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_basic_frames();
      // escaped flag and escape, then a check byte; the closing flag opens the next frame
      send_byte(FLAG_BYTE);
      send_header(CTRL_INFO);
      send_byte(ESC_BYTE);
      send_byte(ESC_OF_FLAG);
      send_byte(ESC_BYTE);
      send_byte(ESC_OF_ESC);
      send_byte(8'hff);
      send_byte(FLAG_BYTE ^ ESC_BYTE ^ 8'hff);
      send_byte(FLAG_BYTE);
      send_header(CTRL_DISC);
      send_byte(8'h55);
      send_byte(FLAG_BYTE);
      // empty frame, then a frame holding only a zero check byte
      send_header(CTRL_INFO);
      send_byte(FLAG_BYTE);
      send_header(CTRL_INFO);
      send_byte(8'h00);
      send_byte(FLAG_BYTE);
      // stray escape, then an escape right before the flag
      send_header(CTRL_INFO);
      send_byte(8'h41);
      send_byte(ESC_BYTE);
      send_byte(8'h22);
      send_byte(8'h41);
      send_byte(FLAG_BYTE);
      send_header(CTRL_INFO);
      send_byte(ESC_BYTE);
      send_byte(FLAG_BYTE);
   endtask

   task automatic test_header_errors();
      send_byte(cfg_address);
      send_byte(8'h05);
      send_byte(FLAG_BYTE);
      send_byte(FLAG_BYTE);
      send_byte(cfg_address);
      send_byte(FLAG_BYTE);
      send_byte(cfg_address);
      send_byte(CTRL_INFO);
      send_byte(8'hc5);
      send_byte(FLAG_BYTE);
      send_byte(cfg_address);
      send_byte(CTRL_DISC);
      send_byte(FLAG_BYTE);
      send_header(CTRL_DISC);
      send_byte(FLAG_BYTE);
   endtask

   task automatic test_register_extremes();
      wait_idle();
      csr_write(CSR_FRAME_ADDRESS, 0);
      csr_write(CSR_MAX_PAYLOAD, 1);
      send_info_frame(3, 0, 1);
      send_info_frame(1, 0, 0);
      wait_idle();
      csr_write(CSR_FRAME_ADDRESS, 255);
      send_info_frame(2, 0, 1);
      wait_idle();
      // an address equal to the flag can never match
      csr_write(CSR_FRAME_ADDRESS, COUNT_WIDTH'(FLAG_BYTE));
      send_info_frame(2, 0, 1);
      wait_idle();
      csr_write(CSR_FRAME_ADDRESS, 3);
      csr_write(CSR_MAX_PAYLOAD, 250);
   endtask

   task automatic test_max_size_frames();
      wait_idle();
      csr_write(CSR_MAX_PAYLOAD, 4096);
      send_info_frame(40, 0, 1);
      send_info_frame(40, 1, 0);
      wait_idle();
   endtask

   task automatic reconfigure();
      wait_idle();
      case ($urandom_range(5))
         0: csr_write(CSR_FRAME_ADDRESS, 0);
         1: csr_write(CSR_FRAME_ADDRESS, 255);
         2: csr_write(CSR_FRAME_ADDRESS, COUNT_WIDTH'(FLAG_BYTE));
         3: csr_write(CSR_FRAME_ADDRESS, 3);
         default: csr_write(CSR_FRAME_ADDRESS, COUNT_WIDTH'($urandom_range(255)));
      endcase
      case ($urandom_range(3))
         0: csr_write(CSR_MAX_PAYLOAD, 1);
         1: csr_write(CSR_MAX_PAYLOAD, COUNT_WIDTH'($urandom_range(2, 12)));
         2: csr_write(CSR_MAX_PAYLOAD, 4096);
         default: csr_write(CSR_MAX_PAYLOAD, 250);
      endcase
   endtask

   task automatic random_traffic(input int n);
      int start;
      int last_cfg;
      int sel;
      int len;
      int pos;
      start = bytes_sent;
      last_cfg = bytes_sent;
      while (bytes_sent - start < n) begin
         if (bytes_sent - last_cfg > 100) begin
            reconfigure();
            last_cfg = bytes_sent;
         end
         sel = $urandom_range(99);
         if (sel < 55) begin
            len = (cfg_max_payload < 10) ? cfg_max_payload + 2 : 12;
            send_info_frame($urandom_range(0, len), $urandom_range(99) < 15,
                            last_sent != FLAG_BYTE || $urandom_range(1));
         end else if (sel < 65) begin
            send_byte(FLAG_BYTE);
            send_header(CTRL_DISC);
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)));
            send_byte(FLAG_BYTE);
         end else if (sel < 75) begin
            // header with one byte replaced
            pos = $urandom_range(2);
            send_byte(FLAG_BYTE);
            send_byte(pos == 0 ? 8'($urandom_range(255)) : cfg_address);
            send_byte(pos == 1 ? 8'($urandom_range(255)) : CTRL_INFO);
            send_byte(pos == 2 ? 8'($urandom_range(255)) : cfg_address ^ CTRL_INFO);
            repeat ($urandom_range(0, 4)) send_byte(pick_payload());
            send_byte(FLAG_BYTE);
         end else if (sel < 90) begin
            // raw data field with loose escapes
            send_byte(FLAG_BYTE);
            send_header(CTRL_INFO);
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(3))
                  0: send_byte(ESC_BYTE);
                  1: send_byte($urandom_range(1) ? ESC_OF_FLAG : ESC_OF_ESC);
                  default: send_byte(8'($urandom_range(255)));
               endcase
            end
            send_byte(FLAG_BYTE);
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      send_idle_pct = 9;
      recv_stall_pct = 73;
      bytes_sent = 0;
      mismatches = 0;
      seen_payload = 0;
      seen_good = 0;
      seen_bad = 0;
      seen_disc = 0;
      last_sent = '0;
      cfg_address = 8'd3;
      cfg_max_payload = 250;
      rx_phase = HUNT;
      clear_frame_state();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_basic_frames();
      test_header_errors();
      test_register_extremes();
      random_traffic(400);
      wait_idle();
      send_idle_pct = 73;
      recv_stall_pct = 9;
      random_traffic(400);
      wait_idle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_max_size_frames();
      random_traffic(400);
      wait_idle();

      $display("sent %0d bytes; checked %0d payload bytes, %0d good, %0d bad, %0d disconnect",
               bytes_sent, seen_payload, seen_good, seen_bad, seen_disc);
      $display("covered escapes, header faults, overflow and address/limit extremes");
      if (mismatches == 0) begin
         $display("byte_stuffed_frame_receiver test passed");
      end else begin
         $display("byte_stuffed_frame_receiver test failed");
      end
      $finish;
   end

endmodule

### byte_stuffed_frame_receiver.f
rtl/bsfr_pkg.sv
rtl/bsfr_front.sv
rtl/bsfr_queue.sv
rtl/bsfr_back.sv
rtl/byte_stuffed_frame_receiver.sv
verif/tb.sv
